// ----- rtl/crc8fr_pkg.sv -----
// Shared types, constants and the CRC-8 byte update for the framed target receiver.
package crc8fr_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] CRC_POLY  = 8'h31;
	localparam logic [7:0] CRC_INIT  = 8'hFF;

	localparam logic [9:0] RST_YELLOW_ANGLE    = 10'd0;
	localparam logic [9:0] RST_YELLOW_DISTANCE = 10'd100;
	localparam logic [9:0] RST_BLUE_ANGLE      = 10'd180;
	localparam logic [9:0] RST_BLUE_DISTANCE   = 10'd80;

	localparam logic [1:0] VIEW_BOTH        = 2'd0;
	localparam logic [1:0] VIEW_NO_YELLOW   = 2'd1;
	localparam logic [1:0] VIEW_NO_BLUE     = 2'd2;
	localparam logic [1:0] VIEW_NONE        = 2'd3;

	localparam int RES_BITS  = 44;
	localparam int TDATA_OUT = 48;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_YA    = 3'd1,
		PH_YD    = 3'd2,
		PH_BA    = 3'd3,
		PH_BD    = 3'd4,
		PH_CHECK = 3'd5
	} phase_t;

	typedef struct packed {
		logic [1:0] view_code;
		logic       blue_seen;
		logic       yellow_seen;
		logic [9:0] blue_distance;
		logic [9:0] blue_angle;
		logic [9:0] yellow_distance;
		logic [9:0] yellow_angle;
	} result_t;

	function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/crc8fr_framer.sv -----
// Frame sequencer: sync hunt, CRC-8 check, held target values and result build.
module crc8fr_framer
	import crc8fr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output result_t    res
);

	phase_t     phase_q, phase_d;
	logic [7:0] crc_q, crc_d;
	logic [7:0] ya_q, yd_q, ba_q, bd_q;
	logic [9:0] held_ya_q, held_yd_q, held_ba_q, held_bd_q;
	logic       good, ys, bs;

	assign ys = (yd_q != 8'd0);
	assign bs = (bd_q != 8'd0);

	always_comb begin
		phase_d   = phase_q;
		crc_d     = crc_q;
		good      = 1'b0;
		case (phase_q)
			PH_YA, PH_YD, PH_BA, PH_BD: begin
				crc_d = crc_feed(crc_q, rx_byte);
				case (phase_q)
					PH_YA:   phase_d = PH_YD;
					PH_YD:   phase_d = PH_BA;
					PH_BA:   phase_d = PH_BD;
					default: phase_d = PH_CHECK;
				endcase
			end
			PH_CHECK: begin
				phase_d = PH_HUNT;
				crc_d   = CRC_INIT;
				good    = (rx_byte == crc_q);
			end
			default: begin
				phase_d = (rx_byte == SYNC_BYTE) ? PH_YA : PH_HUNT;
				crc_d   = CRC_INIT;
			end
		endcase
		res_valid = en && good;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			crc_q   <= CRC_INIT;
		end else if (en) begin
			phase_q <= phase_d;
			crc_q   <= crc_d;
		end
	end

	// capture frame bytes
	always_ff @(posedge clk) begin
		if (en) begin
			case (phase_q)
				PH_YA:   ya_q <= rx_byte;
				PH_YD:   yd_q <= rx_byte;
				PH_BA:   ba_q <= rx_byte;
				PH_BD:   bd_q <= rx_byte;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_ya_q <= RST_YELLOW_ANGLE;
			held_yd_q <= RST_YELLOW_DISTANCE;
			held_ba_q <= RST_BLUE_ANGLE;
			held_bd_q <= RST_BLUE_DISTANCE;
		end else if (res_valid) begin
			if (ys) begin
				held_ya_q <= {ya_q, 2'b00};
				held_yd_q <= {yd_q, 2'b00};
			end
			if (bs) begin
				held_ba_q <= {ba_q, 2'b00};
				held_bd_q <= {bd_q, 2'b00};
			end
		end
	end

	always_comb begin
		res.yellow_angle    = ys ? {ya_q, 2'b00} : held_ya_q;
		res.yellow_distance = ys ? {yd_q, 2'b00} : held_yd_q;
		res.blue_angle      = bs ? {ba_q, 2'b00} : held_ba_q;
		res.blue_distance   = bs ? {bd_q, 2'b00} : held_bd_q;
		res.yellow_seen     = ys;
		res.blue_seen       = bs;
		if (ys && bs) begin
			res.view_code = VIEW_BOTH;
		end else if (bs) begin
			res.view_code = VIEW_NO_YELLOW;
		end else if (ys) begin
			res.view_code = VIEW_NO_BLUE;
		end else begin
			res.view_code = VIEW_NONE;
		end
	end

endmodule

// ----- rtl/crc8fr_out_reg.sv -----
// Result register on the master side of the stream.
module crc8fr_out_reg
	import crc8fr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  result_t              res,
	output logic                 free,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [TDATA_OUT-1:0] m_axis_tdata
);

	logic    valid_q;
	result_t data_q;

	assign free          = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {{(TDATA_OUT - RES_BITS){1'b0}}, data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= res;
		end
	end

endmodule

// ----- rtl/crc8_framed_target_receiver.sv -----
// Framed target receiver: one serial byte per beat, one result beat per good frame.
// A check byte waits in byte_s1; its result is then loaded into the result register.
// Throughput: one byte per cycle; the input stalls only while a result beat waits for tready.
// Reset: hunts for sync, CRC at 0xFF, held values at their defaults, no beat pending.
// Frame data registers are not reset; each is written before its frame is checked.
module crc8_framed_target_receiver
	import crc8fr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // rx_byte[7:0]
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// yellow_angle[9:0], yellow_distance[19:10], blue_angle[29:20],
	// blue_distance[39:30], yellow_seen[40], blue_seen[41], view_code[43:42]
	output logic [TDATA_OUT-1:0] m_axis_tdata
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free, advance, res_valid;
	result_t    res;

	// advance the held byte only when the result register can take a beat
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	crc8fr_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	crc8fr_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (res_valid),
		.res           (res),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
